// File: design/pfr_pkg.sv
// ----------------------------------------------------------------------------
// pfr_pkg: shared types and constants of the particle filter resampler
// Fixed point sizes, function codes, register indexes, controller states,
// divider handshake structs and the xorshift32 step.
// ----------------------------------------------------------------------------
package pfr_pkg;

  localparam int PARTICLES   = 64;
  localparam int PRIOR_DEPTH = 256;
  localparam int PROB_BITS   = 16;

  localparam int WW        = PROB_BITS + 1;          // posteriors and weights, 0..ONE
  localparam int PIDX_W    = $clog2(PARTICLES);
  localparam int PCNT_W    = $clog2(PARTICLES + 1);
  localparam int RIDX_W    = $clog2(PRIOR_DEPTH);
  localparam int RCNT_W    = $clog2(PRIOR_DEPTH + 1);
  localparam int TOT_W     = WW + PIDX_W;
  localparam int PROD_W    = PROB_BITS + TOT_W;
  localparam int DIV_CNT_W = $clog2(WW + 1);
  localparam int PART_W    = 2 * PROB_BITS + 2 * WW;
  localparam int QENT_W    = 3 * WW;

  // fixed widths of the ports
  localparam int FUNC_W    = 2;
  localparam int INDEX_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int KPROB_W   = 16;
  localparam int SEED_W    = 32;
  localparam int RCFG_W    = 9;
  localparam int PCFG_W    = 7;

  localparam logic [WW-1:0] ONE  = {1'b1, {PROB_BITS{1'b0}}};
  localparam logic [WW-1:0] HALF = {2'b01, {(PROB_BITS - 1){1'b0}}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_OBS   = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RESAMPLE_PROB  = 2'd0,
    CFG_PRNG_SEED      = 2'd1,
    CFG_PRIOR_COUNT    = 2'd2,
    CFG_PARTICLE_COUNT = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_IDLE, S_ST_DRAW, S_ST_WR,
    S_UP_RD, S_UP_A, S_UP_B, S_UP_Q, S_UP_WR,
    S_NM_RD, S_NM_S1, S_NM_W1, S_NM_S2, S_NM_W2, S_NM_WR,
    S_DRAW, S_WK_RD, S_WK_CK, S_PK_RD, S_PK_USE,
    S_RS_PRI, S_RS_PWR
  } state_t;

  typedef struct packed {
    logic          start;
    logic [WW-1:0] num;
    logic [WW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [WW-1:0] quot;
  } div_rsp_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

endpackage

// File: design/pfr_in_if.sv
// ----------------------------------------------------------------------------
// pfr_in_if: input item channel
// Valid/ready channel carrying one load, start or observation item.
// ----------------------------------------------------------------------------
interface pfr_in_if;
  import pfr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [INDEX_W-1:0]   prior_index;
  logic [PROB_BITS-1:0] prior_hazard;
  logic [PROB_BITS-1:0] prior_likelihood;
  logic                 observation;

  modport source (output valid, func, prior_index, prior_hazard, prior_likelihood,
                  observation, input ready);
  modport sink (input valid, func, prior_index, prior_hazard, prior_likelihood,
                observation, output ready);
endinterface

// File: design/pfr_out_if.sv
// ----------------------------------------------------------------------------
// pfr_out_if: result channel
// Valid/ready channel carrying the selected particle of an observation.
// ----------------------------------------------------------------------------
interface pfr_out_if;
  import pfr_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [WW-1:0]        state1_posterior;
  logic [WW-1:0]        state2_posterior;
  logic [PROB_BITS-1:0] hazard_sample;
  logic [PROB_BITS-1:0] likelihood_sample;
  logic [WW-1:0]        weight_sample;

  modport source (output valid, state1_posterior, state2_posterior, hazard_sample,
                  likelihood_sample, weight_sample, input ready);
  modport sink (input valid, state1_posterior, state2_posterior, hazard_sample,
                likelihood_sample, weight_sample, output ready);
endinterface

// File: design/hmm_particle_filter_resampler.sv
// ----------------------------------------------------------------------------
// hmm_particle_filter_resampler: SIR particle filter for a two-state HMM
// One item is worked at a time; in_ch.ready is high only while idle. A start
// item draws a prior for each of the N particles in use. An observation runs
// an update pass and a normalize pass (two divisions per particle), then for
// the selection and each of the N resampled particles one draw plus either a
// cumulative-weight walk through the weight memory, visiting up to N
// particles, or (when resampling, taken with probability resample_prob) a
// fresh prior. Particles live in a ping-pong memory (two banks of PARTICLES
// entries), weights and normalized posteriors in a single-bank memory.
// The result sits in an output register, so the block keeps resampling while
// a result waits; it stalls only if a new result finds the old one not taken.
// No clearing pass follows reset.
// ----------------------------------------------------------------------------
module hmm_particle_filter_resampler (
  input  logic                      clk,
  input  logic                      rst,
  pfr_in_if.sink                    in_ch,
  pfr_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [pfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfr_pkg::CFG_W-1:0] cfg_data
);
  import pfr_pkg::*;

  // configuration
  logic [KPROB_W-1:0] resample_prob;
  logic [SEED_W-1:0]  prng_seed;
  logic [RCFG_W-1:0]  prior_count;
  logic [PCFG_W-1:0]  particle_count;

  // control
  state_t state, state_next;
  logic [PIDX_W-1:0] m;
  logic [PIDX_W-1:0] wm;
  logic [PIDX_W-1:0] jsel;
  logic              cur;
  logic              resampling;
  logic              x_r;
  logic [31:0]       rs;
  logic              ov;

  // datapath
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  cum;
  logic [PROD_W-1:0] prod;
  logic [WW-1:0]     a_r, b_r, q1_r, q2_r, n1_r, s1_r, s2_r;
  logic [WW-1:0]     o_s1, o_s2, o_w;
  logic [PROB_BITS-1:0] o_h, o_l;

  // memories
  logic [2*PROB_BITS-1:0] prior_mem [PRIOR_DEPTH];
  logic [PART_W-1:0]      part_mem [2*PARTICLES];
  logic [QENT_W-1:0]      q_mem [PARTICLES];
  logic [2*PROB_BITS-1:0] prior_rd;
  logic [PART_W-1:0]      part_rd;
  logic [QENT_W-1:0]      q_rd;

  logic                   prior_re, prior_we, part_re, part_we, q_re, q_we;
  logic [RIDX_W-1:0]      prior_raddr;
  logic [PIDX_W:0]        part_raddr, part_waddr;
  logic [PART_W-1:0]      part_wdata;
  logic [PIDX_W-1:0]      q_raddr, q_waddr;
  logic [QENT_W-1:0]      q_wdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // combinational helpers
  logic [PCNT_W-1:0]    cnt;
  logic [RCNT_W-1:0]    pcnt;
  logic                 last_m;
  logic                 in_acc;
  logic                 slot_free;
  logic [31:0]          rs_step;
  logic [PROB_BITS-1:0] u_draw;
  logic                 u_lt_k;
  logic [RCNT_W+PROB_BITS-1:0] pick_prod;
  logic [RIDX_W-1:0]    prior_j;
  logic [PROB_BITS-1:0] p_h, p_l;
  logic [WW-1:0]        p_1, p_2, om_h, h_x, l1, l2;
  logic [2*WW:0]        sum_a, sum_b;
  logic [2*WW-1:0]      mq1, mq2;
  logic [WW-1:0]        q_n1, q_n2, q_w;
  logic [TOT_W-1:0]     cum_new;
  logic                 walk_hit;

  always_comb begin
    if (particle_count == '0) begin
      cnt = PCNT_W'(1);
    end else if (32'(particle_count) > PARTICLES) begin
      cnt = PCNT_W'(PARTICLES);
    end else begin
      cnt = PCNT_W'(particle_count);
    end
    if (prior_count == '0) begin
      pcnt = RCNT_W'(1);
    end else if (32'(prior_count) > PRIOR_DEPTH) begin
      pcnt = RCNT_W'(PRIOR_DEPTH);
    end else begin
      pcnt = RCNT_W'(prior_count);
    end
  end

  assign last_m    = {1'b0, m} == PCNT_W'(cnt - 1'b1);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !ov || out_ch.ready;
  assign rs_step   = xorshift32(rs);
  assign u_draw    = rs_step[31 -: PROB_BITS];
  assign u_lt_k    = u_draw < resample_prob[PROB_BITS-1:0];
  assign pick_prod = pcnt * u_draw;
  assign prior_j   = pick_prod[PROB_BITS +: RIDX_W];

  // particle entry {h, l, p1, p2}, weight entry {q1|n1, q2|n2, w}
  assign p_h  = part_rd[PART_W-1 -: PROB_BITS];
  assign p_l  = part_rd[PART_W-PROB_BITS-1 -: PROB_BITS];
  assign p_1  = part_rd[2*WW-1 -: WW];
  assign p_2  = part_rd[WW-1:0];
  assign h_x  = {1'b0, p_h};
  assign om_h = ONE - h_x;
  assign sum_a = (2*WW+1)'(om_h * p_1) + (2*WW+1)'(h_x * p_2);
  assign sum_b = (2*WW+1)'(h_x * p_1) + (2*WW+1)'(om_h * p_2);
  assign l1   = x_r ? {1'b0, p_l} : ONE - {1'b0, p_l};
  assign l2   = ONE - l1;
  assign mq1  = l1 * a_r;
  assign mq2  = l2 * b_r;
  assign q_n1 = q_rd[QENT_W-1 -: WW];
  assign q_n2 = q_rd[2*WW-1 -: WW];
  assign q_w  = q_rd[WW-1:0];

  assign cum_new  = cum + TOT_W'(q_w);
  assign walk_hit = ({cum_new, {PROB_BITS{1'b0}}} > prod) ||
                    ({1'b0, wm} == PCNT_W'(cnt - 1'b1));

  assign in_ch.ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          unique case (func_t'(in_ch.func))
            FUNC_START: state_next = S_ST_DRAW;
            FUNC_OBS:   state_next = S_UP_RD;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_ST_DRAW: state_next = S_ST_WR;
      S_ST_WR:   state_next = last_m ? S_IDLE : S_ST_DRAW;
      S_UP_RD:   state_next = S_UP_A;
      S_UP_A:    state_next = S_UP_B;
      S_UP_B:    state_next = S_UP_Q;
      S_UP_Q:    state_next = S_UP_WR;
      S_UP_WR:   state_next = last_m ? S_NM_RD : S_UP_RD;
      S_NM_RD:   state_next = S_NM_S1;
      S_NM_S1:   state_next = S_NM_W1;
      S_NM_W1:   state_next = div_rsp.done ? S_NM_S2 : S_NM_W1;
      S_NM_S2:   state_next = S_NM_W2;
      S_NM_W2:   state_next = div_rsp.done ? S_NM_WR : S_NM_W2;
      S_NM_WR:   state_next = last_m ? S_DRAW : S_NM_RD;
      S_DRAW:    state_next = (resampling && u_lt_k) ? S_RS_PRI : S_WK_RD;
      S_WK_RD:   state_next = S_WK_CK;
      S_WK_CK:   state_next = walk_hit ? S_PK_RD : S_WK_RD;
      S_PK_RD:   state_next = S_PK_USE;
      S_PK_USE: begin
        if (!resampling) begin
          state_next = slot_free ? S_DRAW : S_PK_USE;
        end else begin
          state_next = last_m ? S_IDLE : S_DRAW;
        end
      end
      S_RS_PRI:  state_next = S_RS_PWR;
      S_RS_PWR:  state_next = last_m ? S_IDLE : S_DRAW;
      default:   state_next = S_IDLE;
    endcase
  end

  // memory and divider controls
  always_comb begin
    prior_we    = in_acc && (func_t'(in_ch.func) == FUNC_LOAD) &&
                  (32'(in_ch.prior_index) < PRIOR_DEPTH);
    prior_re    = (state == S_ST_DRAW) || (state == S_RS_PRI);
    prior_raddr = prior_j;
    part_re     = (state == S_UP_RD) || (state == S_PK_RD);
    part_raddr  = (state == S_PK_RD) ? {cur, jsel} : {cur, m};
    part_we     = 1'b0;
    part_waddr  = {~cur, m};
    part_wdata  = {p_h, p_l, q_n1, q_n2};
    q_re        = (state == S_NM_RD) || (state == S_WK_RD) || (state == S_PK_RD);
    q_raddr     = m;
    q_we        = 1'b0;
    q_waddr     = m;
    q_wdata     = {q1_r, q2_r, WW'(q1_r + q2_r)};
    div_req.start = 1'b0;
    div_req.num   = q_n1;
    div_req.den   = q_w;
    unique case (state)
      S_ST_WR: begin
        part_we    = 1'b1;
        part_waddr = {cur, m};
        part_wdata = {prior_rd, HALF, HALF};
      end
      S_UP_WR: q_we = 1'b1;
      S_NM_S1: div_req.start = 1'b1;
      S_NM_S2: begin
        div_req.start = 1'b1;
        div_req.num   = q_n2;
      end
      S_NM_WR: begin
        q_we    = 1'b1;
        q_wdata = {n1_r, div_rsp.quot, q_w};
      end
      S_WK_RD: q_raddr = wm;
      S_PK_RD: q_raddr = jsel;
      S_PK_USE: part_we = resampling;
      S_RS_PWR: begin
        part_we    = 1'b1;
        part_wdata = {prior_rd, s1_r, s2_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (prior_we) prior_mem[in_ch.prior_index[RIDX_W-1:0]] <=
                    {in_ch.prior_hazard, in_ch.prior_likelihood};
    if (prior_re) prior_rd <= prior_mem[prior_raddr];
  end

  always_ff @(posedge clk) begin
    if (part_we) part_mem[part_waddr] <= part_wdata;
    if (part_re) part_rd <= part_mem[part_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    if (q_re) q_rd <= q_mem[q_raddr];
  end

  pfr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      resample_prob  <= '0;
      prng_seed      <= SEED_W'(1);
      prior_count    <= RCFG_W'(1);
      particle_count <= PCFG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RESAMPLE_PROB:  resample_prob  <= cfg_data[KPROB_W-1:0];
        CFG_PRNG_SEED:      prng_seed      <= cfg_data[SEED_W-1:0];
        CFG_PRIOR_COUNT:    prior_count    <= cfg_data[RCFG_W-1:0];
        CFG_PARTICLE_COUNT: particle_count <= cfg_data[PCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m          <= '0;
      wm         <= '0;
      cur        <= 1'b0;
      resampling <= 1'b0;
      rs         <= 32'd1;
      ov         <= 1'b0;
      total      <= '0;
    end else begin
      state <= state_next;
      if (state == S_PK_USE && !resampling && slot_free) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc && func_t'(in_ch.func) == FUNC_START) begin
            rs <= (prng_seed == '0) ? 32'd1 : prng_seed;
            m  <= '0;
          end
          if (in_acc && func_t'(in_ch.func) == FUNC_OBS) begin
            total      <= '0;
            m          <= '0;
            resampling <= 1'b0;
          end
        end
        S_ST_DRAW: rs <= rs_step;
        S_ST_WR:   m  <= last_m ? '0 : m + 1'b1;
        S_UP_WR: begin
          total <= total + TOT_W'(q1_r + q2_r);
          m     <= last_m ? '0 : m + 1'b1;
        end
        S_NM_WR:   m  <= last_m ? '0 : m + 1'b1;
        S_DRAW: begin
          rs <= rs_step;
          wm <= '0;
        end
        S_WK_CK: if (!walk_hit) wm <= wm + 1'b1;
        S_PK_USE: begin
          if (!resampling) begin
            if (slot_free) begin
              resampling <= 1'b1;
              m          <= '0;
            end
          end else begin
            m <= last_m ? '0 : m + 1'b1;
            if (last_m) cur <= ~cur;
          end
        end
        S_RS_PRI:  rs <= rs_step;
        S_RS_PWR: begin
          m <= last_m ? '0 : m + 1'b1;
          if (last_m) cur <= ~cur;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE:  if (in_acc) x_r <= in_ch.observation;
      S_UP_A:  a_r <= sum_a[PROB_BITS +: WW];
      S_UP_B:  b_r <= sum_b[PROB_BITS +: WW];
      S_UP_Q: begin
        q1_r <= mq1[PROB_BITS +: WW];
        q2_r <= mq2[PROB_BITS +: WW];
      end
      S_NM_W1: if (div_rsp.done) n1_r <= div_rsp.quot;
      S_DRAW: begin
        prod <= PROD_W'(u_draw * total);
        cum  <= '0;
      end
      S_WK_CK: begin
        if (walk_hit) begin
          jsel <= wm;
        end else begin
          cum <= cum_new;
        end
      end
      S_PK_USE: begin
        if (!resampling && slot_free) begin
          o_s1 <= q_n1;
          o_s2 <= q_n2;
          o_h  <= p_h;
          o_l  <= p_l;
          o_w  <= q_w;
          s1_r <= q_n1;
          s2_r <= q_n2;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid             = ov;
  assign out_ch.state1_posterior  = o_s1;
  assign out_ch.state2_posterior  = o_s2;
  assign out_ch.hazard_sample     = o_h;
  assign out_ch.likelihood_sample = o_l;
  assign out_ch.weight_sample     = o_w;

  a_out_from_pick: assert property (@(posedge clk) disable iff (rst)
    $rose(ov) |-> $past(state == S_PK_USE))
    else $error("result raised outside the selection step");

  a_m_in_range: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> {1'b0, m} < cnt)
    else $error("particle index beyond particles in use");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WK_CK |-> {1'b0, wm} < cnt)
    else $error("weight walk beyond particles in use");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule

// File: design/pfr_div.sv
// ----------------------------------------------------------------------------
// pfr_div: posterior normalizer
// Restoring divider, one quotient bit a cycle: quot = (num << PROB_BITS) / den,
// valid for num <= den. A zero divisor gives zero.
// ----------------------------------------------------------------------------
module pfr_div (
  input  logic             clk,
  input  logic             rst,
  input  pfr_pkg::div_req_t req,
  output pfr_pkg::div_rsp_t rsp
);
  import pfr_pkg::*;

  logic [WW-1:0]        rem;
  logic [WW-1:0]        sh;
  logic [WW-1:0]        den;
  logic [WW-1:0]        quot;
  logic [DIV_CNT_W-1:0] left;
  logic                 busy;
  logic                 done;
  logic [WW:0]          rem2;
  logic                 fits;

  assign rem2 = {rem, sh[WW-1]};
  assign fits = rem2 >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        left <= DIV_CNT_W'(WW);
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // the top bits of num << PROB_BITS start as the partial remainder
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.num >> 1;
      sh   <= {req.num[0], {(WW - 1){1'b0}}};
      den  <= req.den;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? WW'(rem2 - {1'b0, den}) : rem2[WW-1:0];
      sh   <= sh << 1;
      quot <= {quot[WW-2:0], fits};
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = (den == '0) ? '0 : quot;

endmodule
